/* hdl/wft_pkg.sv */
`timescale 1ns / 1ps

package wft_pkg;

  // Longest word kept; later bytes of a longer word are dropped.
  localparam int MAX_WORD_LEN = 19;
  // Width of each saturating occurrence count.
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_ENTRIES = 256;

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [7:0] byte_t;
  typedef logic [MAX_WORD_LEN-1:0][7:0] chars_t;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_TEND  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_QEND  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Lookup packet that walks the row of entry cells, one cell per cycle.
  typedef struct packed {
    logic                   vld;
    logic                   qry;
    logic                   hit;
    logic                   alloc;
    logic [LEN_W-1:0]       len;
    chars_t                 chars;
    logic [COUNT_WIDTH-1:0] cnt;
  } pkt_t;

  // Bytes that end a text word.
  function automatic logic is_delim(input byte_t c);
    logic r;
    case (c)
      8'h2E, 8'h20, 8'h2C, 8'h3B, 8'h3A, 8'h2A, 8'h21, 8'h3F,
      8'h27, 8'h2D, 8'h0A, 8'h00, 8'h0D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // ASCII upper case to lower case.
  function automatic byte_t fold_byte(input byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

/* hdl/wft_cell.sv */
`timescale 1ns / 1ps

module wft_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  wft_pkg::pkt_t pkt_i,
  output wft_pkg::pkt_t pkt_o
);

  logic                            valid_r, valid_nxt;
  wft_pkg::chars_t                 chars_r, chars_nxt;
  logic [wft_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [wft_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  wft_pkg::pkt_t                   pkt_r, pkt_nxt;
  logic                            match;

  // Words are stored folded and zero padded, so a whole-vector compare suffices.
  assign match = valid_r && (len_r == pkt_i.len) && (chars_r == pkt_i.chars);

  // Resolve the packet against this cell's entry.
  always_comb begin
    pkt_nxt   = pkt_i;
    valid_nxt = valid_r;
    chars_nxt = chars_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    if (pkt_i.vld && !pkt_i.hit) begin
      if (match) begin
        pkt_nxt.hit = 1'b1;
        if (pkt_i.qry) begin
          pkt_nxt.cnt = cnt_r;
        end else if (cnt_r != wft_pkg::COUNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (!valid_r && !pkt_i.qry) begin
        // First free cell takes the new word.
        valid_nxt     = 1'b1;
        chars_nxt     = pkt_i.chars;
        len_nxt       = pkt_i.len;
        cnt_nxt       = {{(wft_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
        pkt_nxt.hit   = 1'b1;
        pkt_nxt.alloc = 1'b1;
      end
    end
  end

  // Only the entry valid bit and the packet valid bit need a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pkt_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pkt_r   <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    len_r   <= len_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign pkt_o = pkt_r;

endmodule

/* hdl/word_frequency_table_core.sv */
`timescale 1ns / 1ps

// Word frequency counter. Text and query bytes are taken one per cycle while the
// input is not stalled; a byte or an end of text that ends a non-empty word, or an
// end of query, sends the word down a row of NUM_ENTRIES entry cells, one cell per
// cycle, and no further byte is taken until the word leaves the last cell.
// A query result appears in the cycle after its lookup leaves the last cell.

module word_frequency_table_core #(
  parameter int NUM_ENTRIES = wft_pkg::NUM_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [15:0] out_occurrences,
  output logic [8:0]  out_distinct_words,
  output logic        out_table_overflowed
);

  localparam int USED_W = $clog2(NUM_ENTRIES + 1);

  wft_pkg::state_t           state_r, state_nxt;
  wft_pkg::byte_t            buf_r [wft_pkg::MAX_WORD_LEN];
  logic [wft_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [USED_W-1:0]         used_r, used_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r;
  logic [15:0]               occ_r;
  logic [8:0]                dist_r;
  logic                      ovf_out_r;

  wft_pkg::pkt_t chain [NUM_ENTRIES+1];
  wft_pkg::pkt_t launch;
  wft_pkg::pkt_t ex;
  wft_pkg::kind_t kind;

  logic accept, take, commit, qend, go;

  assign kind   = wft_pkg::kind_t'(in_kind);
  assign accept = in_valid && !in_stall;
  assign take   = accept && ((kind == wft_pkg::KIND_TEXT && !wft_pkg::is_delim(in_ch))
                             || kind == wft_pkg::KIND_QUERY);
  assign commit = accept && ((kind == wft_pkg::KIND_TEXT && wft_pkg::is_delim(in_ch))
                             || kind == wft_pkg::KIND_TEND);
  assign qend   = accept && (kind == wft_pkg::KIND_QEND);
  assign go     = qend || (commit && len_r != '0);
  assign ex     = chain[NUM_ENTRIES];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wft_pkg::ST_IDLE: if (go) state_nxt = wft_pkg::ST_BUSY;
      wft_pkg::ST_BUSY: if (ex.vld) state_nxt = wft_pkg::ST_IDLE;
      default:          state_nxt = wft_pkg::ST_IDLE;
    endcase
  end

  // Stall while a lookup is in flight, or a query would find the result slot full.
  always_comb begin
    case (state_r)
      wft_pkg::ST_IDLE: in_stall = out_valid_r && (kind == wft_pkg::KIND_QEND);
      default:          in_stall = 1'b1;
    endcase
  end

  // Build the lookup packet from the folded, zero-padded word buffer.
  always_comb begin
    launch       = '0;
    launch.vld   = go;
    launch.qry   = qend;
    launch.len   = len_r;
    for (int i = 0; i < wft_pkg::MAX_WORD_LEN; i++) begin
      launch.chars[i] = (i < int'(len_r)) ? buf_r[i] : 8'h00;
    end
  end

  assign chain[0] = launch;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    wft_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .pkt_i (chain[g]),
      .pkt_o (chain[g+1])
    );
  end

  // Word length, table fill and overflow bookkeeping.
  always_comb begin
    len_nxt  = len_r;
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    if (take && len_r < wft_pkg::LEN_W'(wft_pkg::MAX_WORD_LEN)) begin
      len_nxt = len_r + 1'b1;
    end else if (commit || qend) begin
      len_nxt = '0;
    end
    if (ex.vld && !ex.qry) begin
      if (ex.alloc) used_nxt = used_r + 1'b1;
      if (!ex.hit)  ovf_nxt  = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ex.vld && ex.qry) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wft_pkg::ST_IDLE;
      len_r       <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Word buffer and result payload.
  always_ff @(posedge clk) begin
    if (take && len_r < wft_pkg::LEN_W'(wft_pkg::MAX_WORD_LEN)) begin
      buf_r[len_r[wft_pkg::IDX_W-1:0]] <= wft_pkg::fold_byte(in_ch);
    end
    if (ex.vld && ex.qry) begin
      found_r   <= ex.hit;
      occ_r     <= ex.hit ? 16'(ex.cnt) : 16'd0;
      dist_r    <= 9'(used_r);
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = found_r;
  assign out_occurrences      = occ_r;
  assign out_distinct_words   = dist_r;
  assign out_table_overflowed = ovf_out_r;

  // No input is taken while a lookup walks the cells.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wft_pkg::ST_BUSY |-> !accept) else $error("input taken during lookup");

  // A packet leaves the row only while a lookup is outstanding.
  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ex.vld |-> state_r == wft_pkg::ST_BUSY) else $error("stray lookup packet");

  // A new result only follows a finished query lookup.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ex.vld && ex.qry)) else $error("result without query");

  // The table never claims more entries than it has.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_r) <= NUM_ENTRIES) else $error("entry count out of range");

endmodule

/* sim/word_frequency_table_checker.sv */
`timescale 1ns / 1ps

module word_frequency_table_checker
  import wft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_ch,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_found,
  input  logic [15:0] out_occurrences,
  input  logic [8:0]  out_distinct_words,
  input  logic        out_table_overflowed,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic                   found;
    logic [COUNT_WIDTH-1:0] occurrences;
    logic [8:0]             distinct_words;
    logic                   overflowed;
  } query_answer_t;

  // Model of the word table.
  byte_t                  tbl_chars [NUM_ENTRIES][MAX_WORD_LEN];
  int                     tbl_len   [NUM_ENTRIES];
  logic [COUNT_WIDTH-1:0] tbl_count [NUM_ENTRIES];
  int                     tbl_used;
  logic                   tbl_overflow;
  byte_t                  cur_word  [MAX_WORD_LEN];
  int                     cur_len;

  query_answer_t answers_due[$];

  function automatic bit ends_word(byte_t c);
    return c inside {8'h2E, 8'h20, 8'h2C, 8'h3B, 8'h3A, 8'h2A, 8'h21, 8'h3F,
                     8'h27, 8'h2D, 8'h0A, 8'h00, 8'h0D};
  endfunction

  function automatic byte_t to_lower(byte_t c);
    return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
  endfunction

  // Index of the entry holding the current word, or tbl_used on a miss.
  function automatic int find_entry();
    int e;
    int i;
    bit same;
    if (cur_len == 0) return tbl_used;
    for (e = 0; e < tbl_used; e++) begin
      if (tbl_len[e] != cur_len) continue;
      same = 1'b1;
      for (i = 0; i < cur_len; i++)
        if (to_lower(tbl_chars[e][i]) != to_lower(cur_word[i])) same = 1'b0;
      if (same) return e;
    end
    return tbl_used;
  endfunction

  function automatic void append_byte(byte_t c);
    if (cur_len < MAX_WORD_LEN) begin
      cur_word[cur_len] = c;
      cur_len++;
    end
  endfunction

  function automatic void count_word();
    int e;
    if (cur_len == 0) return;
    e = find_entry();
    if (e < tbl_used) begin
      if (tbl_count[e] != COUNT_MAX) tbl_count[e]++;
    end else if (tbl_used < NUM_ENTRIES) begin
      for (int i = 0; i < cur_len; i++) tbl_chars[tbl_used][i] = cur_word[i];
      tbl_len[tbl_used] = cur_len;
      tbl_count[tbl_used] = COUNT_WIDTH'(1);
      tbl_used++;
    end else begin
      tbl_overflow = 1'b1;
    end
    cur_len = 0;
  endfunction

  function automatic void take_word(kind_t k, byte_t c);
    query_answer_t a;
    int e;
    case (k)
      KIND_TEXT: begin
        if (ends_word(c)) count_word();
        else append_byte(c);
      end
      KIND_TEND:  count_word();
      KIND_QUERY: append_byte(c);
      default: begin
        e = find_entry();
        a.found = (e < tbl_used);
        a.occurrences = a.found ? tbl_count[e] : '0;
        a.distinct_words = 9'(tbl_used);
        a.overflowed = tbl_overflow;
        answers_due.push_back(a);
        cur_len = 0;
      end
    endcase
  endfunction

  assign pending = answers_due.size();

  // Predict on every accepted input word, compare every accepted result word.
  always @(posedge clk) begin
    query_answer_t want;
    query_answer_t got;
    if (!rst_n) begin
      tbl_used = 0;
      tbl_overflow = 1'b0;
      cur_len = 0;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) take_word(kind_t'(in_kind), in_ch);
      if (out_valid && !out_stall) begin
        got = '{out_found, out_occurrences, out_distinct_words, out_table_overflowed};
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", got);
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

endmodule

/* sim/word_frequency_table_core_tb.sv */
`timescale 1ns / 1ps

module word_frequency_table_core_tb;
  import wft_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [15:0] out_occurrences;
  logic [8:0]  out_distinct_words;
  logic        out_table_overflowed;
  int          fail_count;
  int          pending;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int words_sent = 0;

  byte_t delims[13] = '{8'h2E, 8'h20, 8'h2C, 8'h3B, 8'h3A, 8'h2A, 8'h21, 8'h3F,
                        8'h27, 8'h2D, 8'h0A, 8'h00, 8'h0D};
  string vocab[10] = '{"the", "a", "Cat", "dog", "house", "run", "I", "zebra",
                       "internationalization", "internationalizatioN"};

  word_frequency_table_core uut (.*);

  word_frequency_table_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("word_frequency_table_core regression: fail");
    $finish;
  end

  // Result side: random short stalls, rare longer ones, one long hold on request.
  initial begin
    int run;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (run > 0) begin
        run--;
        out_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 99) < 2) begin
        run = $urandom_range(10, 60);
        out_stall <= 1'b1;
      end else begin
        out_stall <= stalls_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(kind_t k, byte_t c);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_ch <= c;
    do begin
      #1 stalled = in_stall;
      @(posedge clk);
      if (stalled) @(negedge clk);
    end while (stalled);
    @(negedge clk);
    words_sent++;
  endtask

  // When mix_case is set, letters get a random case so lookups are checked case-blind.
  task automatic send_str(kind_t k, string s, bit mix_case);
    byte_t c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
        c = c ^ 8'h20;
      send(k, c);
    end
  endtask

  // Distinct words used to fill the table; they never clash with the vocabulary.
  function automatic string fill_word(int n);
    string s;
    s = "qx";
    s = {s, string'(byte'("a" + n % 26)), string'(byte'("a" + (n / 26) % 26))};
    return s;
  endfunction

  task automatic send_junk_word(kind_t k);
    int n;
    byte_t c;
    n = $urandom_range(0, 100) < 80 ? $urandom_range(1, 6) : $urandom_range(15, 24);
    for (int i = 0; i < n; i++) begin
      c = byte_t'($urandom_range(0, 255));
      if (k == KIND_TEXT && c inside {delims}) c = c | 8'h40;
      send(k, c);
    end
  endtask

  task automatic mixed_traffic(int count, int fill_span);
    int r;
    int goal;
    goal = words_sent + count;
    while (words_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_str(KIND_TEXT, vocab[$urandom_range(0, 9)], 1'b1);
        send(KIND_TEXT, delims[$urandom_range(0, 12)]);
      end else if (r < 55) begin
        send_str(KIND_QUERY, vocab[$urandom_range(0, 9)], 1'b1);
        send(KIND_QEND, byte_t'($urandom_range(0, 255)));
      end else if (r < 63) begin
        send_junk_word(KIND_TEXT);
        send(KIND_TEXT, delims[$urandom_range(0, 12)]);
      end else if (r < 68) begin
        send(KIND_TEND, byte_t'($urandom_range(0, 255)));
      end else if (r < 74) begin
        if ($urandom_range(0, 3) != 0) send_junk_word(KIND_QUERY);
        send(KIND_QEND, byte_t'($urandom_range(0, 255)));
      end else if (r < 80) begin
        send(kind_t'($urandom_range(0, 3)), byte_t'($urandom_range(0, 255)));
      end else if (fill_span > 0) begin
        send_str(KIND_QUERY, fill_word($urandom_range(0, fill_span)), 1'b1);
        send(KIND_QEND, 8'h00);
      end else begin
        send_str(KIND_TEXT, vocab[$urandom_range(0, 9)], 1'b0);
        send(KIND_TEND, 8'hFF);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_TEXT;
    in_ch = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: case folding, both end kinds, empty query, shared buffer, NUL.
    send_str(KIND_TEXT, "Hi,", 1'b0);
    send_str(KIND_TEXT, "hI", 1'b0);
    send(KIND_TEXT, 8'h0D);
    send_str(KIND_QUERY, "HI", 1'b0);
    send(KIND_QEND, 8'h00);
    send(KIND_QEND, 8'hFF);
    send_str(KIND_TEXT, "ok", 1'b0);
    send(KIND_TEND, 8'hFF);
    send(KIND_TEXT, "o");
    send(KIND_QUERY, "k");
    send(KIND_QEND, 8'h00);
    send(KIND_QUERY, ".");
    send(KIND_QEND, 8'h00);
    send(KIND_TEXT, "a");
    send(KIND_TEXT, 8'h00);

    // Random traffic with long words, then a long result hold. Two queries
    // back to back during the hold fill the result slot and stall the input.
    mixed_traffic(200, 0);
    hold_req = 1'b1;
    send(KIND_QEND, 8'h00);
    send(KIND_QEND, 8'h00);
    mixed_traffic(100, 0);

    // Drain completely before continuing, then run without idling for a while.
    in_valid <= 1'b0;
    wait (pending == 0 && !hold_req);
    @(negedge clk);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    mixed_traffic(100, 0);
    gaps_on = 1'b1;
    stalls_on = 1'b1;

    // Fill the table past its capacity so new words are dropped.
    for (int n = 0; n < NUM_ENTRIES + 20; n++) begin
      send_str(KIND_TEXT, fill_word(n), 1'b1);
      send(KIND_TEXT, delims[$urandom_range(0, 12)]);
    end
    mixed_traffic(150, NUM_ENTRIES + 20);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3 * (NUM_ENTRIES + 2)) @(posedge clk);
    if (fail_count == 0) begin
      $display("word_frequency_table_core regression: pass");
    end else begin
      $display("word_frequency_table_core regression: fail");
    end
    $finish;
  end

endmodule
